>>> rtl/mvm_pkg.sv
// Package for the matrix-vector multiply engine: payload structs, register
// indexes, element format constants and the sequencer state type.
// No dependencies.
`default_nettype none

package mvm_pkg;

  // Element format and fixed field widths
  localparam int ELEM_W      = 16;
  localparam int OUT_INDEX_W = 4;
  localparam int DIM_REG_W   = 5;
  localparam int FRAC_W      = 4;

  // Default storage size (square matrix side)
  localparam int MAX_DIM_DEF = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSPOSE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAC_BITS = 2'd3;

  localparam logic [DIM_REG_W-1:0] NUM_ROWS_RST  = 5'd16;
  localparam logic [DIM_REG_W-1:0] NUM_COLS_RST  = 5'd16;
  localparam logic [FRAC_W-1:0]    FRAC_BITS_RST = 4'd12;

  // Input item kinds
  localparam logic MODE_MATRIX = 1'b0;
  localparam logic MODE_VECTOR = 1'b1;

  typedef struct packed {
    logic                     mode;
    logic signed [ELEM_W-1:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic [OUT_INDEX_W-1:0]   out_index;
    logic signed [ELEM_W-1:0] out_value;
    logic                     out_last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

>>> rtl/mvm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/matrix_vector_multiply.sv
// Matrix-vector multiply engine, top level.
// Depends on mvm_pkg and mvm_ram.
//
// The engine keeps a matrix of up to MAX_DIM x MAX_DIM signed 16-bit
// fixed-point weights in a RAM, loaded one item at a time in row-major order
// (mode 0), and keeps them across any number of vectors. Vector items (mode 1)
// go into a second small RAM; the item that completes the vector starts the
// product. With transpose clear the result is M*v (num_cols vector items,
// num_rows results); with transpose set it is the row vector v*M (num_rows
// vector items, num_cols results). Each dot product is summed exactly, shifted
// right arithmetically by frac_bits and saturated to 16 bits. Items are taken
// whenever the engine is idle. After the completing vector item the engine runs
// one multiply-accumulate per cycle through a three-stage read/multiply/add
// pipeline, one dot product at a time, pausing after each dot product until
// its sum can enter the output register (held while out_valid is high and
// out_ready low). No new item is taken during that run; the last result may
// still be waiting in the output register when the engine takes its next item.
// Dimensions of 0 act as 1 and above MAX_DIM as MAX_DIM. Matrix and vector
// counters wrap at the current sizes, so a new matrix can be loaded at any time.
// The user must write configuration only while the engine is idle; the block
// itself does not enforce this, and cfg_ready is always high.
`default_nettype none

module matrix_vector_multiply #(
  parameter int MAX_DIM = mvm_pkg::MAX_DIM_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input items
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire mvm_pkg::in_item_t               in_data,
  // result items
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output mvm_pkg::out_item_t                   out_data,
  // configuration writes
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [mvm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mvm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int EW    = mvm_pkg::ELEM_W;
  localparam int AW    = $clog2(MAX_DIM * MAX_DIM);  // matrix address
  localparam int VW    = $clog2(MAX_DIM);            // vector address / index
  localparam int DW    = $clog2(MAX_DIM + 1);        // a dimension 1..MAX_DIM
  localparam int TW    = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int PW    = 2 * EW;
  localparam int ACC_W = PW + DW;

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((2 ** (EW - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [mvm_pkg::DIM_REG_W-1:0] num_rows_r;
  logic [mvm_pkg::DIM_REG_W-1:0] num_cols_r;
  logic                          transpose_r;
  logic [mvm_pkg::FRAC_W-1:0]    frac_bits_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r  <= mvm_pkg::NUM_ROWS_RST;
      num_cols_r  <= mvm_pkg::NUM_COLS_RST;
      transpose_r <= 1'b0;
      frac_bits_r <= mvm_pkg::FRAC_BITS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mvm_pkg::REG_NUM_ROWS:  num_rows_r  <= cfg_data;
        mvm_pkg::REG_NUM_COLS:  num_cols_r  <= cfg_data;
        mvm_pkg::REG_TRANSPOSE: transpose_r <= cfg_data[0];
        mvm_pkg::REG_FRAC_BITS: frac_bits_r <= cfg_data[mvm_pkg::FRAC_W-1:0];
      endcase
    end
  end

  // Effective dimensions: 0 acts as 1, above MAX_DIM as MAX_DIM
  logic [DW-1:0] rows;
  logic [DW-1:0] cols;
  logic [DW-1:0] len;    // vector length
  logic [DW-1:0] outs;   // result count
  logic [TW-1:0] total;  // matrix element count

  always_comb begin
    if (num_rows_r == '0) begin
      rows = DW'(1);
    end else if (32'(num_rows_r) > MAX_DIM) begin
      rows = DW'(MAX_DIM);
    end else begin
      rows = DW'(num_rows_r);
    end
    if (num_cols_r == '0) begin
      cols = DW'(1);
    end else if (32'(num_cols_r) > MAX_DIM) begin
      cols = DW'(MAX_DIM);
    end else begin
      cols = DW'(num_cols_r);
    end
    len   = transpose_r ? rows : cols;
    outs  = transpose_r ? cols : rows;
    total = TW'(TW'(rows) * TW'(cols));
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  mvm_pkg::state_t state_r, state_nxt;

  logic           in_acc;
  logic           vec_done;     // accepted item completes the vector
  logic           s1_v_r, s1_first_r, s1_last_r;
  logic           s2_v_r, s2_first_r, s2_last_r;
  logic           done_r;       // accumulator holds a finished dot product
  logic           out_load;     // finished sum moves into the output register
  logic           issue;        // one multiply-accumulate read this cycle

  logic [AW-1:0]  mat_cnt_r, mat_cnt_nxt;
  logic [VW-1:0]  vec_cnt_r, vec_cnt_nxt;
  logic [VW-1:0]  vec_wslot;    // slot written by this vector item
  logic [AW-1:0]  mat_wslot;    // slot written by this matrix item

  logic [VW-1:0]  k_r, k_nxt;   // result index
  logic [VW-1:0]  t_r, t_nxt;   // term index within a dot product
  logic [AW-1:0]  addr_r, addr_nxt;
  logic [AW-1:0]  base_r, base_nxt;
  logic           t_end, k_end;

  assign in_acc  = in_valid && in_ready;
  assign t_end   = (DW'(t_r) + DW'(1)) == len;
  assign k_end   = (DW'(k_r) + DW'(1)) == outs;

  // Write slots: a counter at or beyond the current limit restarts at 0
  always_comb begin
    mat_wslot = (TW'(mat_cnt_r) >= total) ? '0 : mat_cnt_r;
    vec_wslot = (DW'(vec_cnt_r) >= len) ? '0 : vec_cnt_r;
    vec_done  = in_acc && (in_data.mode == mvm_pkg::MODE_VECTOR)
                && ((DW'(vec_wslot) + DW'(1)) == len);
  end

  always_comb begin
    mat_cnt_nxt = mat_cnt_r;
    vec_cnt_nxt = vec_cnt_r;
    if (in_acc && (in_data.mode == mvm_pkg::MODE_MATRIX)) begin
      mat_cnt_nxt = ((TW'(mat_wslot) + TW'(1)) >= total) ? '0 : AW'(mat_wslot + AW'(1));
    end
    if (in_acc && (in_data.mode == mvm_pkg::MODE_VECTOR)) begin
      vec_cnt_nxt = vec_done ? '0 : VW'(vec_wslot + VW'(1));
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mvm_pkg::ST_IDLE: if (vec_done) state_nxt = mvm_pkg::ST_RUN;
      mvm_pkg::ST_RUN:  if (t_end) state_nxt = mvm_pkg::ST_FIN;
      mvm_pkg::ST_FIN: begin
        if (out_load) state_nxt = k_end ? mvm_pkg::ST_IDLE : mvm_pkg::ST_RUN;
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      mvm_pkg::ST_IDLE: in_ready = 1'b1;
      mvm_pkg::ST_RUN:  issue    = 1'b1;
      mvm_pkg::ST_FIN:  out_load = done_r && (!out_valid || out_ready);
    endcase
  end

  // Index and address walk. Normal: addr = k*cols + t, step 1.
  // Transpose: addr = t*cols + k, step cols.
  always_comb begin
    k_nxt    = k_r;
    t_nxt    = t_r;
    addr_nxt = addr_r;
    base_nxt = base_r;
    if (vec_done) begin
      k_nxt    = '0;
      t_nxt    = '0;
      addr_nxt = '0;
      base_nxt = '0;
    end else if (issue) begin
      t_nxt    = VW'(t_r + VW'(1));
      addr_nxt = AW'(addr_r + (transpose_r ? AW'(cols) : AW'(1)));
    end else if (out_load && !k_end) begin
      k_nxt    = VW'(k_r + VW'(1));
      t_nxt    = '0;
      base_nxt = AW'(base_r + AW'(cols));
      addr_nxt = transpose_r ? AW'(k_r + VW'(1)) : AW'(base_r + AW'(cols));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mvm_pkg::ST_IDLE;
      mat_cnt_r <= '0;
      vec_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      mat_cnt_r <= mat_cnt_nxt;
      vec_cnt_r <= vec_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    t_r    <= t_nxt;
    addr_r <= addr_nxt;
    base_r <= base_nxt;
  end

  // ---------------------------------------------------------------------------
  // Stores
  // ---------------------------------------------------------------------------
  logic [EW-1:0] mat_rdata;
  logic [EW-1:0] vec_rdata;

  mvm_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_DIM * MAX_DIM)
  ) u_mat_ram (
    .clk   (clk),
    .we    (in_acc && (in_data.mode == mvm_pkg::MODE_MATRIX)),
    .waddr (mat_wslot),
    .wdata (in_data.element_value),
    .raddr (addr_r),
    .rdata (mat_rdata)
  );

  mvm_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_DIM)
  ) u_vec_ram (
    .clk   (clk),
    .we    (in_acc && (in_data.mode == mvm_pkg::MODE_VECTOR)),
    .waddr (vec_wslot),
    .wdata (in_data.element_value),
    .raddr (t_r),
    .rdata (vec_rdata)
  );

  // ---------------------------------------------------------------------------
  // Read -> multiply -> accumulate pipeline
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0]    prod_r, prod_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;

  assign prod_nxt = $signed(mat_rdata) * $signed(vec_rdata);
  assign acc_nxt  = s2_first_r ? ACC_W'(prod_r) : ACC_W'(acc_r + ACC_W'(prod_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
      if (s2_v_r && s2_last_r) begin
        done_r <= 1'b1;
      end else if (out_load) begin
        done_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_first_r <= (t_r == '0);
    s1_last_r  <= t_end;
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    if (s1_v_r) begin
      prod_r <= prod_nxt;
    end
    if (s2_v_r) begin
      acc_r <= acc_nxt;
    end
  end

  // Scale and saturate the finished sum
  logic signed [ACC_W-1:0] shifted;
  logic signed [EW-1:0]    sat_value;

  always_comb begin
    shifted = acc_r >>> frac_bits_r;
    if (shifted > SAT_MAX) begin
      sat_value = EW'(SAT_MAX);
    end else if (shifted < SAT_MIN) begin
      sat_value = EW'(SAT_MIN);
    end else begin
      sat_value = EW'(shifted);
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic               out_valid_r;
  mvm_pkg::out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.out_index <= mvm_pkg::OUT_INDEX_W'(k_r);
      out_data_r.out_value <= sat_value;
      out_data_r.out_last  <= k_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_issue_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> ($past(state_r) == mvm_pkg::ST_RUN))
    else $error("read issued outside the run state");

  a_drained_at_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!s1_v_r && !s2_v_r))
    else $error("result taken while terms still in flight");

  a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != mvm_pkg::ST_IDLE) |-> (DW'(k_r) < outs))
    else $error("result index beyond result count");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && k_end) |=> (state_r == mvm_pkg::ST_IDLE) && out_data.out_last)
    else $error("final result did not end the run");

  a_no_load_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !out_load)
    else $error("output register overwritten");

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for matrix_vector_multiply: a clocked driver, a result
// monitor and a GEMV predictor with its own weight and vector stores.
// Depends on mvm_pkg and the matrix_vector_multiply RTL.

module tb_top;
  import mvm_pkg::*;

  localparam int IDLE_LIMIT   = 2000;  // cycles with no handshake of any kind
  localparam int DRAIN_CYCLES = 20;    // settle time once nothing is expected
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int ITEM_TARGET  = 420;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  matrix_vector_multiply uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stimulus and expectation stores
  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int        items_queued = 0;
  int        fail_count   = 0;
  int        idle_cycles  = 0;
  bit        in_taken     = 1'b0;  // set at the edge that accepts the offered item
  bit        steady       = 1'b0;  // no idling on either side
  bit        hold_request = 1'b0;
  bit        hold_done    = 1'b0;
  int        hold_left    = 0;

  // Shadow of the engine: registers, resident weights, vector and counters
  logic [DIM_REG_W-1:0]     cur_rows      = NUM_ROWS_RST;
  logic [DIM_REG_W-1:0]     cur_cols      = NUM_COLS_RST;
  logic                     cur_transpose = 1'b0;
  logic [FRAC_W-1:0]        cur_frac      = FRAC_BITS_RST;
  logic signed [ELEM_W-1:0] weights   [MAX_DIM_DEF*MAX_DIM_DEF];
  logic signed [ELEM_W-1:0] vec_elems [MAX_DIM_DEF];
  int                       weight_ptr = 0;
  int                       vec_ptr    = 0;

  // 0 acts as 1, anything past the store size as the store size
  function automatic int eff_dim(input logic [DIM_REG_W-1:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM_DEF) return MAX_DIM_DEF;
    return int'(d);
  endfunction

  // Applies one accepted item to the shadow; the completing vector item
  // queues the whole result vector.
  task automatic gemv_predict(input in_item_t it);
    int        rows, cols, len, outs, addr;
    longint    acc;
    out_item_t res;
    rows = eff_dim(cur_rows);
    cols = eff_dim(cur_cols);
    if (it.mode == MODE_MATRIX) begin
      if (weight_ptr >= rows * cols) weight_ptr = 0;
      weights[weight_ptr] = it.element_value;
      weight_ptr++;
      if (weight_ptr >= rows * cols) weight_ptr = 0;
    end else begin
      len = cur_transpose ? rows : cols;
      if (vec_ptr >= len) vec_ptr = 0;
      vec_elems[vec_ptr] = it.element_value;
      vec_ptr++;
      if (vec_ptr == len) begin
        vec_ptr = 0;
        outs = cur_transpose ? cols : rows;
        for (int k = 0; k < outs; k++) begin
          acc = 0;
          for (int t = 0; t < len; t++) begin
            addr = cur_transpose ? (t * cols + k) : (k * cols + t);
            acc += longint'(weights[addr]) * longint'(vec_elems[t]);
          end
          acc = acc >>> cur_frac;  // floor, not round
          res.out_index = k[OUT_INDEX_W-1:0];
          if (acc > 32767)
            res.out_value = 16'sh7FFF;
          else if (acc < -32768)
            res.out_value = 16'sh8000;
          else
            res.out_value = acc[ELEM_W-1:0];
          res.out_last = (k == outs - 1);
          expected_results.push_back(res);
        end
      end
    end
  endtask

  // Input driver: changes on the falling edge, keeps an item up until taken
  always @(negedge clk) begin : drive_items
    bit       offer;
    in_item_t nxt;
    offer = in_valid && !in_taken;
    nxt   = in_data;
    in_taken = 1'b0;
    if (rst_n && !offer && pending_items.size() != 0 &&
        (steady || $urandom_range(0, 99) >= 30)) begin
      nxt   = pending_items.pop_front();
      offer = 1'b1;
    end
    in_valid <= offer;
    in_data  <= nxt;
  end

  // Result receiver: random back-pressure plus one long hold-off
  always @(negedge clk) begin : drive_ready
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(0, 99) >= 30);
    end
  end

  // Monitor: predicts on accepted items, checks accepted results, tracks
  // register writes and watches for a hang.
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NUM_ROWS:  cur_rows      = cfg_data;
          REG_NUM_COLS:  cur_cols      = cfg_data;
          REG_TRANSPOSE: cur_transpose = cfg_data[0];
          REG_FRAC_BITS: cur_frac      = cfg_data[FRAC_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        gemv_predict(in_data);
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: out_index %0d out_value %0d out_last %0b",
                 out_data.out_index, out_data.out_value, out_data.out_last);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.out_index !== want.out_index) begin
            $error("out_index: expected %0d, got %0d", want.out_index, out_data.out_index);
            fail_count++;
          end
          if (out_data.out_value !== want.out_value) begin
            $error("out_value: expected %0d, got %0d", want.out_value, out_data.out_value);
            fail_count++;
          end
          if (out_data.out_last !== want.out_last) begin
            $error("out_last: expected %0b, got %0b", want.out_last, out_data.out_last);
            fail_count++;
          end
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("matrix_vector_multiply test failed");
      $finish;
    end
  end

  function automatic logic signed [ELEM_W-1:0] pick_value();
    logic [ELEM_W-1:0] raw;
    raw = ELEM_W'($urandom_range(0, 65535));
    case ($urandom_range(0, 15))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      3:       return -16'sd1;
      default: return raw;
    endcase
  endfunction

  // Mostly small sizes; zero and out-of-range now and then
  function automatic logic [DIM_REG_W-1:0] pick_dim();
    case ($urandom_range(0, 19))
      0:       return 5'd0;
      1:       return DIM_REG_W'($urandom_range(17, 31));
      2:       return 5'd16;
      default: return DIM_REG_W'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [FRAC_W-1:0] pick_frac();
    case ($urandom_range(0, 5))
      0:       return 4'd0;
      1:       return 4'd15;
      default: return FRAC_W'($urandom_range(0, 15));
    endcase
  endfunction

  task automatic queue_item(input logic mode, input logic signed [ELEM_W-1:0] value);
    in_item_t it;
    it.mode          = mode;
    it.element_value = value;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Unused upper data bits are filled at random; the engine must ignore them
  task automatic set_shape(input logic [DIM_REG_W-1:0] rows_reg,
                           input logic [DIM_REG_W-1:0] cols_reg,
                           input logic tr, input logic [FRAC_W-1:0] frac);
    logic [3:0] junk;
    junk = 4'($urandom_range(0, 15));
    write_reg(REG_NUM_ROWS, rows_reg);
    write_reg(REG_NUM_COLS, cols_reg);
    write_reg(REG_TRANSPOSE, {junk, tr});
    write_reg(REG_FRAC_BITS, {junk[3], frac});
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Sender stays quiet until every result is in and the engine has settled
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One setting: full weight load, a few vectors with stray weight writes,
  // sometimes a broken tail left for the next setting to cope with.
  task automatic run_phase(input logic [DIM_REG_W-1:0] rows_reg,
                           input logic [DIM_REG_W-1:0] cols_reg,
                           input logic tr, input logic [FRAC_W-1:0] frac,
                           input bit with_hold, input bit no_gaps);
    int rows, cols, len, total;
    set_shape(rows_reg, cols_reg, tr, frac);
    rows  = eff_dim(rows_reg);
    cols  = eff_dim(cols_reg);
    len   = tr ? rows : cols;
    total = rows * cols;
    steady = no_gaps;
    repeat (total) queue_item(MODE_MATRIX, pick_value());
    repeat ($urandom_range(2, 5)) begin
      for (int t = 0; t < len; t++) begin
        if ($urandom_range(0, 99) < 8) queue_item(MODE_MATRIX, pick_value());
        queue_item(MODE_VECTOR, pick_value());
      end
    end
    case ($urandom_range(0, 3))
      0:       repeat ($urandom_range(0, len - 1)) queue_item(MODE_VECTOR, pick_value());
      1:       repeat ($urandom_range(1, total)) queue_item(MODE_MATRIX, pick_value());
      default: ;
    endcase
    if (with_hold) hold_request = 1'b1;
    wait_drained();
    steady = 1'b0;
  endtask

  initial begin : stimulus
    logic [DIM_REG_W-1:0] r, c;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // 2x2, no fraction bits: products large enough to saturate both ways
    set_shape(5'd2, 5'd2, 1'b0, 4'd0);
    queue_item(MODE_MATRIX, 16'sh7FFF);
    queue_item(MODE_MATRIX, 16'sh8000);
    queue_item(MODE_MATRIX, 16'sd1);
    queue_item(MODE_MATRIX, -16'sd1);
    queue_item(MODE_VECTOR, 16'sh7FFF);
    queue_item(MODE_VECTOR, 16'sh8000);
    queue_item(MODE_VECTOR, 16'sh8000);
    queue_item(MODE_VECTOR, 16'sh7FFF);
    wait_drained();

    // same weights, row vector times matrix, widest fraction: truncation
    // toward minus infinity on small negative sums
    set_shape(5'd2, 5'd2, 1'b1, 4'd15);
    queue_item(MODE_VECTOR, -16'sd1);
    queue_item(MODE_VECTOR, 16'sd0);
    queue_item(MODE_VECTOR, 16'sd1);
    queue_item(MODE_VECTOR, 16'sd1);
    wait_drained();

    // zero rows acts as one: 1x1, weight counter wraps on every load
    set_shape(5'd0, 5'd1, 1'b0, 4'd15);
    queue_item(MODE_MATRIX, -16'sd1);
    queue_item(MODE_VECTOR, 16'sh8000);
    queue_item(MODE_VECTOR, 16'sh7FFF);
    queue_item(MODE_MATRIX, 16'sd5);
    queue_item(MODE_MATRIX, 16'sh7FFF);
    queue_item(MODE_VECTOR, 16'sh8000);
    wait_drained();

    // receiver holds off while items keep coming, so the engine backs up
    run_phase(5'd3, 5'd4, 1'b0, pick_frac(), 1'b1, 1'b0);
    // run with no idling on either side
    run_phase(5'd5, 5'd2, 1'b1, pick_frac(), 1'b0, 1'b1);
    // extremes: oversized column count, full-height transpose
    run_phase(5'd1, 5'd17, 1'b0, 4'd0, 1'b0, 1'b0);
    run_phase(5'd31, 5'd2, 1'b1, 4'd15, 1'b0, 1'b0);
    run_phase(5'd16, 5'd1, 1'b0, 4'd8, 1'b0, 1'b0);

    while (items_queued < ITEM_TARGET) begin
      r = pick_dim();
      c = pick_dim();
      if (eff_dim(r) * eff_dim(c) > 64) c = DIM_REG_W'($urandom_range(1, 4));
      run_phase(r, c, 1'($urandom_range(0, 1)), pick_frac(), 1'b0, 1'b0);
    end

    if (fail_count == 0)
      $display("matrix_vector_multiply test passed");
    else
      $display("matrix_vector_multiply test failed");
    $finish;
  end

endmodule
